// ===== hw/rtl/fcca_pkg.sv =====
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared types and constants of the cluster chain allocator: request and
// response payloads, command and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package fcca_pkg;

	// table geometry and field widths
	localparam int NUM_CLUSTERS_DEF = 1024;
	localparam int CL_W             = 16;
	localparam int BYTES_W          = 32;
	localparam int NEED_W           = BYTES_W + 1;
	localparam int SCAN_W           = 11;
	localparam int LOG2_W           = 4;
	localparam int FREED_W          = 11;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_W            = 11;
	localparam int FIRST_DATA       = 2;

	// entry codes
	localparam logic [CL_W-1:0] END_MARK = 16'hFFFF;

	// configuration reset values
	localparam logic [SCAN_W-1:0] SCAN_LIMIT_RST   = 11'd1000;
	localparam logic [LOG2_W-1:0] CLUSTER_LOG2_RST = 4'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_LOG2 = 1'b1;

	// request commands
	typedef enum logic [2:0] {
		CMD_ALLOC  = 3'd0,
		CMD_FREE   = 3'd1,
		CMD_READ   = 3'd2,
		CMD_EXTEND = 3'd3,
		CMD_WRITE  = 3'd4
	} cmd_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_SPACE     = 2'd1,
		ST_OUT_OF_RANGE = 2'd2,
		ST_BROKEN       = 2'd3
	} status_t;

	// response field source
	typedef enum logic [1:0] {
		RSEL_ZERO  = 2'd0,
		RSEL_FIRST = 2'd1,
		RSEL_RDATA = 2'd2,
		RSEL_COUNT = 2'd3
	} rsp_sel_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [CL_W-1:0]     cluster;
		logic [BYTES_W-1:0]  byte_count;
		logic [CL_W-1:0]     entry_value;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [CL_W-1:0]     result_cluster;
		logic [FREED_W-1:0]  freed_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic     clr_step;
		logic     req_load;
		logic     scan_start;
		logic     scan_run;
		logic     scan_link;
		logic     alloc_end;
		logic     ext_link;
		logic     ext_end;
		logic     wr_entry;
		logic     rd_next;
		logic     free_start;
		logic     free_rd;
		logic     free_ev;
		logic     rsp_load;
		status_t  rsp_status;
		rsp_sel_t rsp_sel;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic in_range;
		logic scan_done;
		logic scan_short;
		logic free_end;
		logic free_bad;
		logic free_full;
		logic rsp_busy;
	} dp_stat_t;

endpackage

// ===== hw/rtl/fat_cluster_chain_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_unit
// FAT16-style cluster table with allocate, free, read, extend and write
// commands.
// ----------------------------------------------------------------------------
// Usage
// - request channel req_valid/req_ready/req carries one command; the
//   response channel rsp_valid/rsp_ready/rsp returns one result per request
// - requests are handled one at a time; the table memory has a single read
//   and a single write port, and that port sets the timing
// - allocate: two first-fit passes of one entry per cycle over clusters
//   2 .. L-1 (L = min(scan_limit, NUM_CLUSTERS)), the second only if the
//   first finds enough; extend: one pass up to the first free cluster
// - free: walks the chain, reading each link and then clearing its entry
// - after reset a clearing pass writes every entry to zero with req_ready
//   low; config writes are taken throughout
// - a stalled response stays in the output register; the next request is
//   taken as soon as the result of the current one is loaded there
// - config: cfg_we writes cfg_wdata into register cfg_index (0 scan limit,
//   1 log2 of cluster size), to be written only while the block is idle
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_unit #(
	parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fcca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcca_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  fcca_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output fcca_pkg::rsp_t                   rsp
);

	fcca_pkg::ctrl_cmd_t ctrl_cmd;
	fcca_pkg::dp_stat_t  dp_stat;

	// controller
	fcca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat)
	);

	// datapath
	fcca_dp #(
		.NUM_CLUSTERS (NUM_CLUSTERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (ctrl_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/fcca_dp.sv =====
// ----------------------------------------------------------------------------
// fcca_dp
// Datapath: configuration registers, cluster table memory, first-fit scan
// engine, chain walk counters and the response register.
// ----------------------------------------------------------------------------
module fcca_dp #(
	parameter int NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fcca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fcca_pkg::CFG_W-1:0]       cfg_wdata,
	input  fcca_pkg::req_t                   req,
	input  fcca_pkg::ctrl_cmd_t              cmd,
	output fcca_pkg::dp_stat_t               stat,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output fcca_pkg::rsp_t                   rsp
);

	localparam int CW     = $clog2(NUM_CLUSTERS);
	localparam int CNTW   = $clog2(NUM_CLUSTERS + 1);
	localparam int LIMW   = (CNTW > fcca_pkg::SCAN_W) ? CNTW : fcca_pkg::SCAN_W;
	localparam int RANGEW = fcca_pkg::CL_W + 1;

	logic [fcca_pkg::SCAN_W-1:0] scan_limit_q;
	logic [fcca_pkg::LOG2_W-1:0] log2_q;
	logic [LIMW-1:0]             lim_wide;
	logic [CNTW-1:0]             lim;
	logic [fcca_pkg::NEED_W-1:0] round_add;
	logic [fcca_pkg::NEED_W-1:0] need_calc;
	logic [fcca_pkg::NEED_W-1:0] need_q;
	logic [fcca_pkg::CL_W-1:0]   cluster_q;
	logic [fcca_pkg::CL_W-1:0]   entry_value_q;
	logic [CNTW-1:0]             scan_addr_q;
	logic [CNTW-1:0]             found_q;
	logic                        rd_v_s1;
	logic [CW-1:0]               addr_s1;
	logic [CW-1:0]               prev_q;
	logic [CW-1:0]               first_q;
	logic [CW-1:0]               seed_q;
	logic [CNTW-1:0]             n_q;
	logic [CW-1:0]               clr_q;
	logic                        addr_left;
	logic                        want;
	logic                        issue;
	logic                        hit;
	logic                        we;
	logic [CW-1:0]               waddr;
	logic [fcca_pkg::CL_W-1:0]   wdata;
	logic                        re;
	logic [CW-1:0]               raddr;
	logic [fcca_pkg::CL_W-1:0]   rdata_s1;
	logic [fcca_pkg::CL_W-1:0]   mem [NUM_CLUSTERS];
	logic                        rsp_valid_q;
	fcca_pkg::rsp_t              rsp_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= fcca_pkg::SCAN_LIMIT_RST;
			log2_q       <= fcca_pkg::CLUSTER_LOG2_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcca_pkg::CFG_SCAN_LIMIT:   scan_limit_q <= cfg_wdata;
				fcca_pkg::CFG_CLUSTER_LOG2: log2_q <= cfg_wdata[fcca_pkg::LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	// effective scan limit, clamped to table size
	assign lim_wide = LIMW'(scan_limit_q);
	assign lim = (lim_wide >= LIMW'(NUM_CLUSTERS)) ? CNTW'(NUM_CLUSTERS) : CNTW'(lim_wide);

	// cluster count, rounded up
	assign round_add = fcca_pkg::NEED_W'(req.byte_count)
		+ ((fcca_pkg::NEED_W'(1) << log2_q) - fcca_pkg::NEED_W'(1));
	assign need_calc = round_add >> log2_q;

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			cluster_q     <= req.cluster;
			entry_value_q <= req.entry_value;
			if (req.cmd == fcca_pkg::CMD_EXTEND || need_calc == '0) begin
				need_q <= fcca_pkg::NEED_W'(1);
			end else begin
				need_q <= need_calc;
			end
		end
	end

	// scan engine: one read issued per cycle, data checked in the cycle after
	assign addr_left = scan_addr_q < lim;
	assign want      = fcca_pkg::NEED_W'(found_q) < need_q;
	assign issue     = cmd.scan_run & addr_left & want;
	assign hit       = cmd.scan_run & rd_v_s1 & (rdata_s1 == '0) & want;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			found_q     <= '0;
			rd_v_s1     <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_addr_q <= CNTW'(fcca_pkg::FIRST_DATA);
			found_q     <= '0;
			rd_v_s1     <= 1'b0;
		end else if (cmd.scan_run) begin
			rd_v_s1 <= issue;
			if (issue) begin
				scan_addr_q <= scan_addr_q + CNTW'(1);
			end
			if (hit) begin
				found_q <= found_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= scan_addr_q[CW-1:0];
		end
		if (hit) begin
			if (found_q == '0) begin
				first_q <= addr_s1;
			end
			prev_q <= addr_s1;
		end
	end

	// chain walk and clearing pass counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.free_start) begin
				n_q <= '0;
			end else if (cmd.free_ev) begin
				n_q <= n_q + CNTW'(1);
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.free_start) begin
			seed_q <= cluster_q[CW-1:0];
		end else if (cmd.free_ev) begin
			seed_q <= rdata_s1[CW-1:0];
		end
	end

	// write port select
	always_comb begin
		we    = 1'b0;
		waddr = seed_q;
		wdata = '0;
		if (cmd.clr_step) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (hit && cmd.scan_link && found_q != '0) begin
			we    = 1'b1;
			waddr = prev_q;
			wdata = fcca_pkg::CL_W'(addr_s1);
		end else if (cmd.alloc_end) begin
			we    = 1'b1;
			waddr = prev_q;
			wdata = fcca_pkg::END_MARK;
		end else if (cmd.ext_link) begin
			we    = 1'b1;
			waddr = cluster_q[CW-1:0];
			wdata = fcca_pkg::CL_W'(first_q);
		end else if (cmd.ext_end) begin
			we    = 1'b1;
			waddr = first_q;
			wdata = fcca_pkg::END_MARK;
		end else if (cmd.wr_entry) begin
			we    = 1'b1;
			waddr = cluster_q[CW-1:0];
			wdata = entry_value_q;
		end else if (cmd.free_ev) begin
			we    = 1'b1;
			waddr = seed_q;
		end
	end

	// read port select
	assign re    = issue | cmd.rd_next | cmd.free_rd;
	assign raddr = issue ? scan_addr_q[CW-1:0] : (cmd.rd_next ? cluster_q[CW-1:0] : seed_q);

	// cluster table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// status back to the controller
	assign stat.clr_done   = clr_q == CW'(NUM_CLUSTERS - 1);
	assign stat.in_range   = RANGEW'(cluster_q) < RANGEW'(NUM_CLUSTERS);
	assign stat.scan_done  = !want || (!addr_left && !rd_v_s1);
	assign stat.scan_short = want;
	assign stat.free_end   = rdata_s1 == fcca_pkg::END_MARK;
	assign stat.free_bad   = RANGEW'(rdata_s1) >= RANGEW'(NUM_CLUSTERS);
	assign stat.free_full  = n_q == CNTW'(NUM_CLUSTERS - 1);
	assign stat.rsp_busy   = rsp_valid_q & ~rsp_ready;

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.status <= cmd.rsp_status;
			case (cmd.rsp_sel)
				fcca_pkg::RSEL_FIRST: begin
					rsp_q.result_cluster <= fcca_pkg::CL_W'(first_q);
					rsp_q.freed_count    <= '0;
				end
				fcca_pkg::RSEL_RDATA: begin
					rsp_q.result_cluster <= rdata_s1;
					rsp_q.freed_count    <= '0;
				end
				fcca_pkg::RSEL_COUNT: begin
					rsp_q.result_cluster <= '0;
					rsp_q.freed_count    <= fcca_pkg::FREED_W'(n_q);
				end
				default: begin
					rsp_q.result_cluster <= '0;
					rsp_q.freed_count    <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/fcca_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcca_ctrl
// Controller: sequences the clearing pass, request decode, the two scan
// passes, chain walks and response hand-off.
// ----------------------------------------------------------------------------
module fcca_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  fcca_pkg::cmd_t       req_cmd,
	output logic                 req_ready,
	output fcca_pkg::ctrl_cmd_t  cmd,
	input  fcca_pkg::dp_stat_t   stat
);

	typedef enum logic [11:0] {
		S_CLEAR     = 12'b0000_0000_0001,
		S_IDLE      = 12'b0000_0000_0010,
		S_DECODE    = 12'b0000_0000_0100,
		S_SCAN1     = 12'b0000_0000_1000,
		S_SCAN2     = 12'b0000_0001_0000,
		S_ALLOC_END = 12'b0000_0010_0000,
		S_EXT_LINK  = 12'b0000_0100_0000,
		S_EXT_END   = 12'b0000_1000_0000,
		S_FREE_RD   = 12'b0001_0000_0000,
		S_FREE_EV   = 12'b0010_0000_0000,
		S_RD_NEXT   = 12'b0100_0000_0000,
		S_RESP      = 12'b1000_0000_0000
	} state_t;

	state_t              state_q;
	state_t              state_d;
	fcca_pkg::cmd_t      cmd_q;
	fcca_pkg::status_t   status_q;
	fcca_pkg::status_t   status_d;
	fcca_pkg::rsp_sel_t  sel_q;
	fcca_pkg::rsp_sel_t  sel_d;
	logic                set_rsp;

	// next state and command decode
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		set_rsp   = 1'b0;
		status_d  = fcca_pkg::ST_OK;
		sel_d     = fcca_pkg::RSEL_ZERO;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				set_rsp = 1'b1;
				state_d = S_RESP;
				unique case (cmd_q)
					fcca_pkg::CMD_ALLOC: begin
						set_rsp        = 1'b0;
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN1;
					end
					fcca_pkg::CMD_FREE: begin
						if (stat.in_range) begin
							set_rsp        = 1'b0;
							cmd.free_start = 1'b1;
							state_d        = S_FREE_RD;
						end else begin
							status_d = fcca_pkg::ST_OUT_OF_RANGE;
						end
					end
					fcca_pkg::CMD_READ: begin
						if (stat.in_range) begin
							set_rsp = 1'b0;
							state_d = S_RD_NEXT;
						end else begin
							status_d = fcca_pkg::ST_OUT_OF_RANGE;
						end
					end
					fcca_pkg::CMD_EXTEND: begin
						if (stat.in_range) begin
							set_rsp        = 1'b0;
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN1;
						end else begin
							status_d = fcca_pkg::ST_OUT_OF_RANGE;
						end
					end
					fcca_pkg::CMD_WRITE: begin
						if (stat.in_range) begin
							cmd.wr_entry = 1'b1;
						end else begin
							status_d = fcca_pkg::ST_OUT_OF_RANGE;
						end
					end
					default: ;
				endcase
			end
			// counting pass, also finds the first free cluster
			S_SCAN1: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					if (stat.scan_short) begin
						set_rsp  = 1'b1;
						status_d = fcca_pkg::ST_NO_SPACE;
						state_d  = S_RESP;
					end else if (cmd_q == fcca_pkg::CMD_ALLOC) begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN2;
					end else begin
						state_d = S_EXT_LINK;
					end
				end
			end
			// linking pass
			S_SCAN2: begin
				cmd.scan_run  = 1'b1;
				cmd.scan_link = 1'b1;
				if (stat.scan_done) begin
					state_d = S_ALLOC_END;
				end
			end
			S_ALLOC_END: begin
				cmd.alloc_end = 1'b1;
				set_rsp       = 1'b1;
				sel_d         = fcca_pkg::RSEL_FIRST;
				state_d       = S_RESP;
			end
			S_EXT_LINK: begin
				cmd.ext_link = 1'b1;
				state_d      = S_EXT_END;
			end
			S_EXT_END: begin
				cmd.ext_end = 1'b1;
				set_rsp     = 1'b1;
				sel_d       = fcca_pkg::RSEL_FIRST;
				state_d     = S_RESP;
			end
			// chain walk: read a link, then clear it
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_d     = S_FREE_EV;
			end
			S_FREE_EV: begin
				cmd.free_ev = 1'b1;
				if (stat.free_end) begin
					set_rsp = 1'b1;
					sel_d   = fcca_pkg::RSEL_COUNT;
					state_d = S_RESP;
				end else if (stat.free_bad || stat.free_full) begin
					set_rsp  = 1'b1;
					status_d = fcca_pkg::ST_BROKEN;
					sel_d    = fcca_pkg::RSEL_COUNT;
					state_d  = S_RESP;
				end else begin
					state_d = S_FREE_RD;
				end
			end
			S_RD_NEXT: begin
				cmd.rd_next = 1'b1;
				set_rsp     = 1'b1;
				sel_d       = fcca_pkg::RSEL_RDATA;
				state_d     = S_RESP;
			end
			// wait for a free response slot
			S_RESP: begin
				cmd.rsp_status = status_q;
				cmd.rsp_sel    = sel_q;
				if (!stat.rsp_busy) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and held response code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cmd_q    <= fcca_pkg::CMD_ALLOC;
			status_q <= fcca_pkg::ST_OK;
			sel_q    <= fcca_pkg::RSEL_ZERO;
		end else begin
			state_q <= state_d;
			if (req_valid && req_ready) begin
				cmd_q <= req_cmd;
			end
			if (set_rsp) begin
				status_q <= status_d;
				sel_q    <= sel_d;
			end
		end
	end

endmodule

// ===== hw/rtl/fcca_checker.sv =====
// ----------------------------------------------------------------------------
// fcca_checker
// Port-level checks of the cluster chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fcca_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input fcca_pkg::rsp_t rsp
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// only a chain walk reports a freed count
	a_count_src: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.freed_count != '0 |->
			rsp.status == fcca_pkg::ST_OK || rsp.status == fcca_pkg::ST_BROKEN)
		else $error("freed count on a failing or non-free response");

	// failing responses carry no cluster
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != fcca_pkg::ST_OK |-> rsp.result_cluster == '0)
		else $error("cluster returned with a failing status");

endmodule

bind fat_cluster_chain_allocator_unit fcca_checker u_fcca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cluster chain allocator. A directed table of
// requests runs first at the reset settings. Random traffic follows over
// several scan limit and cluster size settings, under different idle and
// stall patterns. Every response is checked in order against typed-in
// expectations or a behavioral model of the cluster table.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCL = fcca_pkg::NUM_CLUSTERS_DEF;
	localparam longint RUN_LIMIT_NS = 40_000_000;

	// command codes the block ignores
	localparam logic [2:0] CMD_RSVD_LO = 3'd5;
	localparam logic [2:0] CMD_RSVD_HI = 3'd7;

	typedef struct {
		fcca_pkg::req_t  item;
		bit              typed;
		fcca_pkg::rsp_t  want;
	} dir_row_t;

	typedef struct {
		int lim;
		int log2;
		int snd_idle;
		int rcv_stall;
		int count;
	} phase_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [fcca_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fcca_pkg::CFG_W-1:0]     cfg_wdata;
	logic                           req_valid;
	logic                           req_ready;
	fcca_pkg::req_t                 req;
	logic                           rsp_valid;
	logic                           rsp_ready;
	fcca_pkg::rsp_t                 rsp;

	// model of the cluster table and its settings
	logic [fcca_pkg::CL_W-1:0]   fat_tbl [NCL];
	logic [fcca_pkg::SCAN_W-1:0] scan_lim_q;
	logic [fcca_pkg::LOG2_W-1:0] clus_log2_q;

	fcca_pkg::rsp_t            rsp_due[$];
	logic [fcca_pkg::CL_W-1:0] live_heads[$];
	dir_row_t                  dir_rows[$];

	int             mismatches;
	int             send_idle_pct;
	int             rcv_stall_pct;
	bit             row_typed;
	fcca_pkg::rsp_t row_want;
	bit             req_taken;

	fat_cluster_chain_allocator_unit #(
		.NUM_CLUSTERS(NCL)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop if the block hangs
	initial begin
		#RUN_LIMIT_NS;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic int unsigned eff_limit();
		return (scan_lim_q > NCL) ? NCL : scan_lim_q;
	endfunction

	// last cluster of a chain, stopping at an end mark, a free entry or a bad link
	function automatic logic [fcca_pkg::CL_W-1:0] tail_of(
			input logic [fcca_pkg::CL_W-1:0] head);
		logic [fcca_pkg::CL_W-1:0] c;
		logic [fcca_pkg::CL_W-1:0] nx;
		int                        k;
		c = head;
		for (k = 0; k < NCL; k++) begin
			nx = fat_tbl[c];
			if (nx == fcca_pkg::END_MARK || nx == '0 || nx >= NCL)
				break;
			c = nx;
		end
		return c;
	endfunction

	// apply one request to the table model and work out its response
	task automatic fat_apply(input fcca_pkg::req_t r, output fcca_pkg::rsp_t o);
		int unsigned               lim;
		int unsigned               c;
		int unsigned               prev;
		int unsigned               first;
		int unsigned               seed;
		int unsigned               n;
		logic [fcca_pkg::CL_W-1:0] nxt;
		longint unsigned           unit_bytes;
		longint unsigned           need;
		longint unsigned           found;
		bit                        in_rng;
		o = '0;
		lim = eff_limit();
		in_rng = r.cluster < NCL;
		case (r.cmd)
			fcca_pkg::CMD_ALLOC: begin
				unit_bytes = 64'd1 << clus_log2_q;
				need = ({32'd0, r.byte_count} + unit_bytes - 64'd1) >> clus_log2_q;
				if (need == 0)
					need = 1;
				// first pass only counts free clusters
				found = 0;
				for (c = fcca_pkg::FIRST_DATA; c < lim && found < need; c++)
					if (fat_tbl[c] == '0)
						found++;
				if (found < need) begin
					o.status = fcca_pkg::ST_NO_SPACE;
				end else begin
					// second pass links them in ascending order
					found = 0;
					prev = 0;
					first = 0;
					for (c = fcca_pkg::FIRST_DATA; c < lim && found < need; c++) begin
						if (fat_tbl[c] != '0)
							continue;
						if (found == 0)
							first = c;
						else
							fat_tbl[prev] = fcca_pkg::CL_W'(c);
						prev = c;
						found++;
					end
					fat_tbl[prev] = fcca_pkg::END_MARK;
					o.status = fcca_pkg::ST_OK;
					o.result_cluster = fcca_pkg::CL_W'(first);
				end
			end
			fcca_pkg::CMD_FREE: begin
				if (!in_rng) begin
					o.status = fcca_pkg::ST_OUT_OF_RANGE;
				end else begin
					seed = 32'(r.cluster);
					n = 0;
					o.status = fcca_pkg::ST_BROKEN;
					while (n < NCL) begin
						nxt = fat_tbl[seed];
						fat_tbl[seed] = '0;
						n++;
						if (nxt == fcca_pkg::END_MARK) begin
							o.status = fcca_pkg::ST_OK;
							break;
						end
						if (nxt >= NCL)
							break;
						seed = 32'(nxt);
					end
					o.freed_count = n[fcca_pkg::FREED_W-1:0];
				end
			end
			fcca_pkg::CMD_READ: begin
				if (!in_rng)
					o.status = fcca_pkg::ST_OUT_OF_RANGE;
				else
					o.result_cluster = fat_tbl[r.cluster];
			end
			fcca_pkg::CMD_EXTEND: begin
				if (!in_rng) begin
					o.status = fcca_pkg::ST_OUT_OF_RANGE;
				end else begin
					for (c = fcca_pkg::FIRST_DATA; c < lim; c++)
						if (fat_tbl[c] == '0)
							break;
					if (c >= lim) begin
						o.status = fcca_pkg::ST_NO_SPACE;
					end else begin
						// tail link first, so extending a free tail onto itself ends it
						fat_tbl[r.cluster] = fcca_pkg::CL_W'(c);
						fat_tbl[c] = fcca_pkg::END_MARK;
						o.result_cluster = fcca_pkg::CL_W'(c);
					end
				end
			end
			fcca_pkg::CMD_WRITE: begin
				if (!in_rng)
					o.status = fcca_pkg::ST_OUT_OF_RANGE;
				else
					fat_tbl[r.cluster] = r.entry_value;
			end
			default: o = '0;
		endcase
	endtask

	// one clock: check a response, record an accepted request, pick the stall
	task automatic tick();
		fcca_pkg::rsp_t want;
		fcca_pkg::rsp_t got;
		@(posedge clk);
		req_taken = 1'b0;
		if (rsp_valid && rsp_ready) begin
			if (rsp_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status %0d cluster %h freed %0d",
						rsp.status, rsp.result_cluster, rsp.freed_count);
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status || rsp.result_cluster !== want.result_cluster ||
						rsp.freed_count !== want.freed_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected status %0d cluster %h freed %0d, ",
							"got status %0d cluster %h freed %0d"},
							want.status, want.result_cluster, want.freed_count,
							rsp.status, rsp.result_cluster, rsp.freed_count);
				end
			end
		end
		if (req_valid && req_ready) begin
			fat_apply(req, got);
			rsp_due.push_back(row_typed ? row_want : got);
			if (req.cmd == fcca_pkg::CMD_ALLOC && got.status == fcca_pkg::ST_OK)
				live_heads.push_back(got.result_cluster);
			req_taken = 1'b1;
		end
		rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
	endtask

	// offer one request and hold it until it is taken
	task automatic send_item(input fcca_pkg::req_t item, input bit typed,
			input fcca_pkg::rsp_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			tick();
		end
		req <= item;
		req_valid <= 1'b1;
		row_typed = typed;
		row_want = want;
		do
			tick();
		while (!req_taken);
	endtask

	// let every outstanding response come back, then tick on with no request
	task automatic drain();
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			tick();
		repeat (4) tick();
	endtask

	task automatic set_config(input int lim, input int log2);
		cfg_we <= 1'b1;
		cfg_index <= fcca_pkg::CFG_SCAN_LIMIT;
		cfg_wdata <= fcca_pkg::CFG_W'(lim);
		scan_lim_q = fcca_pkg::SCAN_W'(lim);
		tick();
		cfg_index <= fcca_pkg::CFG_CLUSTER_LOG2;
		cfg_wdata <= fcca_pkg::CFG_W'(log2);
		clus_log2_q = fcca_pkg::LOG2_W'(log2);
		tick();
		cfg_we <= 1'b0;
	endtask

	// random request, mostly aimed at live chains and the scanned range
	task automatic gen_item(output fcca_pkg::req_t item);
		int unsigned lim;
		int unsigned roll;
		int unsigned sel;
		int unsigned nclus;
		int unsigned idx;
		lim = eff_limit();
		roll = $urandom_range(0, 99);
		item.cmd = fcca_pkg::CMD_READ;
		item.cluster = fcca_pkg::CL_W'($urandom);
		item.byte_count = $urandom;
		item.entry_value = fcca_pkg::CL_W'($urandom);
		if (roll < 30) begin
			item.cmd = fcca_pkg::CMD_ALLOC;
			sel = $urandom_range(0, 9);
			// sel 0 keeps a full-width size, almost always too large
			if (sel >= 2) begin
				nclus = (sel == 2) ? $urandom_range(5, 40) : $urandom_range(1, 4);
				item.byte_count = ((nclus - 1) << clus_log2_q) +
					$urandom_range(1, 1 << clus_log2_q);
			end else if (sel == 1) begin
				item.byte_count = '0;
			end
		end else if (roll < 55) begin
			item.cmd = fcca_pkg::CMD_FREE;
			if (live_heads.size() != 0 && $urandom_range(0, 9) < 8) begin
				idx = $urandom_range(0, live_heads.size() - 1);
				item.cluster = live_heads[idx];
				live_heads.delete(idx);
			end else if ($urandom_range(0, 1)) begin
				item.cluster = fcca_pkg::CL_W'($urandom_range(0, lim));
			end
		end else if (roll < 67) begin
			item.cmd = fcca_pkg::CMD_EXTEND;
			if (live_heads.size() != 0 && $urandom_range(0, 9) < 8)
				item.cluster = tail_of(live_heads[$urandom_range(0, live_heads.size() - 1)]);
			else if ($urandom_range(0, 1))
				item.cluster = fcca_pkg::CL_W'($urandom_range(0, lim));
		end else if (roll < 80) begin
			if ($urandom_range(0, 9) < 8)
				item.cluster = fcca_pkg::CL_W'($urandom_range(0, lim + 1));
		end else if (roll < 95) begin
			item.cmd = fcca_pkg::CMD_WRITE;
			if ($urandom_range(0, 9) < 9)
				item.cluster = fcca_pkg::CL_W'($urandom_range(0, lim));
			case ($urandom_range(0, 3))
				0: item.entry_value = fcca_pkg::END_MARK;
				1: item.entry_value =
					fcca_pkg::CL_W'($urandom_range(fcca_pkg::FIRST_DATA, lim - 1));
				2: item.entry_value = '0;
				default: ;
			endcase
		end else begin
			item.cmd = fcca_pkg::cmd_t'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
		end
	endtask

	function automatic dir_row_t mk_row(input fcca_pkg::cmd_t cmd,
			input logic [fcca_pkg::CL_W-1:0] cl,
			input logic [fcca_pkg::BYTES_W-1:0] nbytes,
			input logic [fcca_pkg::CL_W-1:0] val, input bit typed,
			input fcca_pkg::status_t st, input logic [fcca_pkg::CL_W-1:0] rc,
			input logic [fcca_pkg::FREED_W-1:0] fc);
		dir_row_t row;
		row.item.cmd = cmd;
		row.item.cluster = cl;
		row.item.byte_count = nbytes;
		row.item.entry_value = val;
		row.typed = typed;
		row.want.status = st;
		row.want.result_cluster = rc;
		row.want.freed_count = fc;
		return row;
	endfunction

	initial begin
		phase_t         phases[6];
		fcca_pkg::req_t item;
		int             p;
		int             k;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		row_typed = 1'b0;
		row_want = '0;
		req_taken = 1'b0;
		for (k = 0; k < NCL; k++)
			fat_tbl[k] = '0;
		scan_lim_q = fcca_pkg::SCAN_LIMIT_RST;
		clus_log2_q = fcca_pkg::CLUSTER_LOG2_RST;

		// directed requests at the reset settings; expectations typed in where obvious
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd1023, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd1024, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OUT_OF_RANGE, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_ALLOC, 16'd0, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd2, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_ALLOC, 16'd0, 32'd1, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd3, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_ALLOC, 16'd0, 32'd512, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd4, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_ALLOC, 16'd0, 32'd513, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd5, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
			1'b1, fcca_pkg::ST_NO_SPACE, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd5, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd6, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd6, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, fcca_pkg::END_MARK, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_EXTEND, 16'd6, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd7, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_FREE, 16'd5, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd3));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_FREE, 16'd1024, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OUT_OF_RANGE, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_WRITE, 16'hFFFF, 32'd0, fcca_pkg::END_MARK,
			1'b1, fcca_pkg::ST_OUT_OF_RANGE, 16'd0, 11'd0));
		// extend onto a free tail that is itself the first free cluster
		dir_rows.push_back(mk_row(fcca_pkg::CMD_EXTEND, 16'd5, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd5, 11'd0));
		// link past the table end breaks the chain after one entry
		dir_rows.push_back(mk_row(fcca_pkg::CMD_WRITE, 16'd20, 32'd0, 16'h0400, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_FREE, 16'd20, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_BROKEN, 16'd0, 11'd1));
		// free entry links to cluster 0, which loops until the table size is reached
		dir_rows.push_back(mk_row(fcca_pkg::CMD_FREE, 16'd30, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_BROKEN, 16'd0, 11'd1024));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_WRITE, 16'd1023, 32'd0, 16'h00FF, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd1023, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'h00FF, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_WRITE, 16'd0, 32'd0, 16'hFF00, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_READ, 16'd0, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'hFF00, 11'd0));
		// ignored commands give an all-zero response
		dir_rows.push_back(mk_row(fcca_pkg::cmd_t'(CMD_RSVD_HI), 16'hFFFF, 32'hFFFF_FFFF,
			16'hFFFF, 1'b1, fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::cmd_t'(CMD_RSVD_LO), 16'd0, 32'd0, 16'd0, 1'b1,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_ALLOC, 16'd0, 32'h0000_1000, 16'd0, 1'b0,
			fcca_pkg::ST_OK, 16'd0, 11'd0));
		dir_rows.push_back(mk_row(fcca_pkg::CMD_EXTEND, 16'd2, 32'd0, 16'd0, 1'b0,
			fcca_pkg::ST_OK, 16'd0, 11'd0));

		// random phases: scan limit, cluster size, sender idle, receiver stall, requests
		phases = '{
			'{40, 9, 0, 0, 46},
			'{3, 15, 66, 0, 46},
			'{1024, 12, 0, 66, 46},
			'{16, 10, 36, 36, 46},
			'{200, 15, 0, 0, 46},
			'{512, 13, 0, 66, 46}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

		for (p = 0; p < 6; p++) begin
			drain();
			set_config(phases[p].lim, phases[p].log2);
			send_idle_pct = phases[p].snd_idle;
			rcv_stall_pct = phases[p].rcv_stall;
			for (k = 0; k < phases[p].count; k++) begin
				gen_item(item);
				send_item(item, 1'b0, '0);
			end
		end

		drain();
		repeat (20) tick();
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
